// ===== rtl/dcd_pkg.sv =====
// Shared types and constants for the detection cluster dispatcher.
package dcd_pkg;
	localparam int MaxClusters = 64;
	localparam int MaxDrones = 16;
	localparam int CIdxW = 6;
	localparam int CntW = 7;
	localparam int DIdxW = 4;

	localparam logic [1:0] ACT_DETECT = 2'd0;
	localparam logic [1:0] ACT_STATUS = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	localparam logic [1:0] MODE_UNKNOWN = 2'd0;
	localparam logic [1:0] MODE_IDLE    = 2'd1;
	localparam logic [1:0] MODE_BUSY    = 2'd2;
	localparam logic [1:0] MODE_ABSENT  = 2'd3;

	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_MERGED   = 3'd1;
	localparam logic [2:0] KIND_NEW      = 3'd2;
	localparam logic [2:0] KIND_DROPPED  = 3'd3;
	localparam logic [2:0] KIND_IGNORED  = 3'd4;
	localparam logic [2:0] KIND_DISPATCH = 3'd5;

	localparam logic [1:0] REG_ACTIVE  = 2'd0;
	localparam logic [1:0] REG_RADIUS  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [16:0] TickMax = 17'h1FFFF;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_SCAN_RD, ST_SCAN_CMP, ST_SCAN_ACC,
		ST_APPLY, ST_FETCH, ST_FETCH_WAIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic scan_start;   // clear scan pointer/best
		logic scan_rd;      // issue read at scan pointer, advance
		logic scan_cmp;     // register squared terms / product
		logic scan_acc;     // fold into best
		logic dispatch;     // scan mode: 1 = dispatch score
		logic apply;        // write detection outcome
		logic fetch;        // read chosen entry
		logic out_load;     // load output register
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic table_empty;
	} stat_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] cluster_index;
		logic [15:0] hits;
		logic signed [23:0] best_x;
		logic signed [23:0] best_y;
		logic signed [23:0] best_z;
		logic [15:0] best_confidence;
		logic [31:0] best_tag;
	} result_t;
endpackage

// ===== rtl/detection_cluster_dispatcher.sv =====
// Top level: stream ports, configuration port, controller and datapath.
// Requests carry the action in s_axis_tuser (detection, drone status, one-second tick);
// each accepted request gives exactly one result, its kind in m_axis_tuser. One request
// is in work at a time. A detection scans every stored cluster in turn (one table read,
// one squaring/product stage and one compare per entry), then updates the table, reads
// the entry back and loads the output; a dispatching tick scans the same way, then reads
// the chosen entry back and loads the output. Status reports, plain ticks and detections
// after a dispatch go straight to the output, and tready comes back once the result is
// loaded. The result waits in an output register; a second result stalls the block until
// the first is taken. Configuration writes belong in gaps with no request in work.
module detection_cluster_dispatcher (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// x, y, z position, confidence, detection tag, drone index, drone mode
	// (lowest first), two zero pad bits
	input  logic [127:0] s_axis_tdata,
	// action
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// cluster_index, hits, best_x, best_y, best_z, best_confidence, best_tag
	// (lowest first), two zero pad bits
	output logic [143:0] m_axis_tdata,
	// kind
	output logic [2:0] m_axis_tuser,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	dcd_pkg::cmd_t cmd;
	dcd_pkg::stat_t stat;
	dcd_pkg::result_t res;
	logic busy, start, dispatched, dispatch_due, out_free, ovalid_q;
	logic [1:0] action;

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;

	dcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.dispatched(dispatched), .dispatch_due(dispatch_due),
		.out_free(out_free), .stat(stat), .cmd(cmd), .busy(busy)
	);

	dcd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .start(start),
		.in_data({s_axis_tdata[125:0], s_axis_tuser}), .cfg_we(cfg_we),
		.cfg_idx(cfg_index),
		.cfg_data(cfg_data), .stat(stat), .dispatched(dispatched),
		.dispatch_due(dispatch_due), .action(action), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.out_load) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tuser = res.kind;
	assign m_axis_tdata = {2'd0, res.best_tag, res.best_confidence, res.best_z,
		res.best_y, res.best_x, res.hits, res.cluster_index};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("accept while busy");
	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid) else $error("result lost");
	a_disp_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dispatched |=> dispatched) else $error("dispatch flag cleared");
endmodule

// ===== rtl/dcd_ctrl.sv =====
// Sequencer for detection, status and tick requests.
module dcd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] action,
	input  logic dispatched,
	input  logic dispatch_due,
	input  logic out_free,
	input  dcd_pkg::stat_t stat,
	output dcd_pkg::cmd_t cmd,
	output logic busy
);
	dcd_pkg::state_t state_q, state_d;
	logic disp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcd_pkg::ST_IDLE;
			disp_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dcd_pkg::ST_DECIDE)
				disp_q <= (action == dcd_pkg::ACT_TICK);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dcd_pkg::ST_IDLE: if (start) state_d = dcd_pkg::ST_DECIDE;
			dcd_pkg::ST_DECIDE: begin
				if (action == dcd_pkg::ACT_DETECT && !dispatched)
					state_d = stat.table_empty ? dcd_pkg::ST_APPLY : dcd_pkg::ST_SCAN_RD;
				else if (action == dcd_pkg::ACT_TICK && dispatch_due)
					state_d = dcd_pkg::ST_SCAN_RD;
				else
					state_d = dcd_pkg::ST_OUT;
			end
			dcd_pkg::ST_SCAN_RD: state_d = dcd_pkg::ST_SCAN_CMP;
			dcd_pkg::ST_SCAN_CMP: state_d = dcd_pkg::ST_SCAN_ACC;
			dcd_pkg::ST_SCAN_ACC: begin
				if (!stat.scan_done) state_d = dcd_pkg::ST_SCAN_RD;
				else if (disp_q) state_d = dcd_pkg::ST_FETCH;
				else state_d = dcd_pkg::ST_APPLY;
			end
			dcd_pkg::ST_APPLY: state_d = dcd_pkg::ST_FETCH;
			dcd_pkg::ST_FETCH: state_d = dcd_pkg::ST_FETCH_WAIT;
			dcd_pkg::ST_FETCH_WAIT: state_d = dcd_pkg::ST_OUT;
			dcd_pkg::ST_OUT: if (out_free) state_d = dcd_pkg::ST_IDLE;
			default: state_d = dcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.dispatch = disp_q;
		busy = (state_q != dcd_pkg::ST_IDLE);
		case (state_q)
			dcd_pkg::ST_DECIDE: begin
				cmd.scan_start = 1'b1;
				cmd.dispatch = (action == dcd_pkg::ACT_TICK);
			end
			dcd_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
			dcd_pkg::ST_SCAN_CMP: cmd.scan_cmp = 1'b1;
			dcd_pkg::ST_SCAN_ACC: cmd.scan_acc = 1'b1;
			dcd_pkg::ST_APPLY: cmd.apply = 1'b1;
			dcd_pkg::ST_FETCH: cmd.fetch = 1'b1;
			dcd_pkg::ST_OUT: cmd.out_load = out_free;
			default: ;
		endcase
	end
endmodule

// ===== rtl/dcd_dp.sv =====
// Cluster table, distance and score scan, drone state and tick counter.
module dcd_dp (
	input  logic clk,
	input  logic arst_n,
	input  dcd_pkg::cmd_t cmd,
	input  logic start,
	input  logic [127:0] in_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	output dcd_pkg::stat_t stat,
	output logic dispatched,
	output logic dispatch_due,
	output logic [1:0] action,
	output dcd_pkg::result_t res
);
	logic [4:0] active_q;
	logic [15:0] radius_q, timeout_q;
	logic signed [23:0] ix_q, iy_q, iz_q;
	logic [15:0] iconf_q;
	logic [31:0] itag_q;
	logic [1:0] act_q;

	logic [23:0] mx [dcd_pkg::MaxClusters];
	logic [23:0] my [dcd_pkg::MaxClusters];
	logic [23:0] mz [dcd_pkg::MaxClusters];
	logic [15:0] mc [dcd_pkg::MaxClusters];
	logic [31:0] mt [dcd_pkg::MaxClusters];
	logic [15:0] mh [dcd_pkg::MaxClusters];

	logic [dcd_pkg::CntW-1:0] total_q, ptr_q, ptr_prev;
	logic [1:0] drone_q [dcd_pkg::MaxDrones];
	logic begun_q, disp_q;
	logic [16:0] ticks_q;

	logic signed [23:0] rx_q, ry_q, rz_q;
	logic [15:0] rc_q, rh_q;
	logic [31:0] rt_q;
	logic [47:0] sx_s2, sy_s2, sz_s2;
	logic [32:0] score_s2;
	logic [49:0] best_q;
	logic found_q;
	logic [dcd_pkg::CIdxW-1:0] bidx_q, cur_q, widx_q;
	logic [2:0] kind_q;
	logic [dcd_pkg::CIdxW-1:0] rdaddr;
	logic [24:0] dx, dy, dz;
	logic [49:0] sqdist;
	logic [31:0] radius_sq;
	dcd_pkg::result_t res_d, res_q;

	assign action = act_q;
	assign dispatched = disp_q;
	assign stat.scan_done = (ptr_q == total_q);
	assign stat.table_empty = (total_q == '0);
	assign radius_sq = 32'(radius_q) * 32'(radius_q);
	// pointer has already advanced past the entry being compared
	assign ptr_prev = ptr_q - 1'b1;

	// input capture
	always_ff @(posedge clk) begin
		if (start) begin
			act_q <= in_data[1:0];
			ix_q <= in_data[25:2];
			iy_q <= in_data[49:26];
			iz_q <= in_data[73:50];
			iconf_q <= in_data[89:74];
			itag_q <= in_data[121:90];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd4;
			radius_q <= 16'd256;
			timeout_q <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_idx)
				dcd_pkg::REG_ACTIVE: active_q <= cfg_data[4:0];
				dcd_pkg::REG_RADIUS: radius_q <= cfg_data;
				dcd_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// reported / idle tests over the drone table
	logic rep_ok, idle_ok;
	always_comb begin
		rep_ok = (active_q <= 5'(dcd_pkg::MaxDrones));
		idle_ok = 1'b1;
		for (int i = 0; i < dcd_pkg::MaxDrones; i++) begin
			if (drone_q[i] == dcd_pkg::MODE_UNKNOWN) rep_ok = 1'b0;
			if (5'(i) < active_q && drone_q[i] == dcd_pkg::MODE_ABSENT) rep_ok = 1'b0;
			if (drone_q[i] != dcd_pkg::MODE_ABSENT && drone_q[i] != dcd_pkg::MODE_IDLE)
				idle_ok = 1'b0;
		end
	end
	// evaluated in DECIDE, after the tick has been counted at start
	assign dispatch_due = !disp_q && begun_q && rep_ok && total_q != '0 &&
		(idle_ok || ticks_q > {1'b0, timeout_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dcd_pkg::MaxDrones; i++) drone_q[i] <= dcd_pkg::MODE_ABSENT;
			begun_q <= 1'b0;
			disp_q <= 1'b0;
			ticks_q <= '0;
			total_q <= '0;
		end else begin
			if (start && in_data[1:0] == dcd_pkg::ACT_STATUS)
				drone_q[in_data[125:122]] <= (in_data[127:126] == dcd_pkg::MODE_ABSENT)
					? dcd_pkg::MODE_BUSY : in_data[127:126];
			if (start && in_data[1:0] == dcd_pkg::ACT_TICK && !disp_q && begun_q &&
				ticks_q != dcd_pkg::TickMax)
				ticks_q <= ticks_q + 17'd1;
			if (start && in_data[1:0] == dcd_pkg::ACT_DETECT && !disp_q)
				begun_q <= 1'b1;
			if (cmd.fetch && cmd.dispatch) disp_q <= 1'b1;
			if (cmd.apply && !found_q && total_q != dcd_pkg::CntW'(dcd_pkg::MaxClusters))
				total_q <= total_q + 1'b1;
		end
	end

	// scan: read, square/multiply, accumulate
	assign rdaddr = cmd.fetch ? widx_q : ptr_q[dcd_pkg::CIdxW-1:0];
	always_ff @(posedge clk) begin
		if (cmd.scan_rd || cmd.fetch) begin
			rx_q <= mx[rdaddr];
			ry_q <= my[rdaddr];
			rz_q <= mz[rdaddr];
			rc_q <= mc[rdaddr];
			rt_q <= mt[rdaddr];
			rh_q <= mh[rdaddr];
		end
	end

	always_comb begin
		dx = (25'(rx_q) - 25'(ix_q));
		dy = (25'(ry_q) - 25'(iy_q));
		dz = (25'(rz_q) - 25'(iz_q));
		if (dx[24]) dx = -dx;
		if (dy[24]) dy = -dy;
		if (dz[24]) dz = -dz;
		sqdist = 50'(sx_s2) + 50'(sy_s2) + 50'(sz_s2);
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_cmp) begin
			sx_s2 <= dx[23:0] * dx[23:0];
			sy_s2 <= dy[23:0] * dy[23:0];
			sz_s2 <= dz[23:0] * dz[23:0];
			score_s2 <= rc_q * (17'(rh_q) + 17'd10);
			cur_q <= ptr_prev[dcd_pkg::CIdxW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			ptr_q <= '0;
			found_q <= 1'b0;
			bidx_q <= '0;
			best_q <= cmd.dispatch ? '0 : 50'(radius_sq);
		end else if (cmd.scan_rd) begin
			ptr_q <= ptr_q + 1'b1;
		end else if (cmd.scan_acc) begin
			if (cmd.dispatch) begin
				if (cur_q == '0 || 50'(score_s2) > best_q) begin
					best_q <= 50'(score_s2);
					bidx_q <= cur_q;
				end
			end else if (sqdist < best_q) begin
				best_q <= sqdist;
				bidx_q <= cur_q;
				found_q <= 1'b1;
			end
		end
	end

	// apply detection outcome to the table
	logic full;
	assign full = (total_q == dcd_pkg::CntW'(dcd_pkg::MaxClusters));
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (found_q) begin
				widx_q <= bidx_q;
				kind_q <= dcd_pkg::KIND_MERGED;
			end else if (!full) begin
				widx_q <= total_q[dcd_pkg::CIdxW-1:0];
				kind_q <= dcd_pkg::KIND_NEW;
			end else begin
				kind_q <= dcd_pkg::KIND_DROPPED;
			end
		end else if (cmd.scan_start) begin
			widx_q <= bidx_q;
			kind_q <= dcd_pkg::KIND_NONE;
		end else if (cmd.scan_acc && cmd.dispatch && stat.scan_done) begin
			widx_q <= (cur_q == '0 || 50'(score_s2) > best_q) ? cur_q : bidx_q;
		end else if (cmd.fetch && cmd.dispatch) begin
			kind_q <= dcd_pkg::KIND_DISPATCH;
		end
	end

	// merged entries: read-modify-write through the fetch path
	logic merge_pend_q, merge_upd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_pend_q <= 1'b0;
			merge_upd_q <= 1'b0;
		end else begin
			merge_pend_q <= cmd.fetch && !cmd.dispatch && kind_q == dcd_pkg::KIND_MERGED;
			merge_upd_q <= merge_pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && !found_q && !full) begin
			mx[total_q[dcd_pkg::CIdxW-1:0]] <= ix_q;
			my[total_q[dcd_pkg::CIdxW-1:0]] <= iy_q;
			mz[total_q[dcd_pkg::CIdxW-1:0]] <= iz_q;
			mc[total_q[dcd_pkg::CIdxW-1:0]] <= iconf_q;
			mt[total_q[dcd_pkg::CIdxW-1:0]] <= itag_q;
			mh[total_q[dcd_pkg::CIdxW-1:0]] <= 16'd1;
		end else if (merge_pend_q) begin
			if (rh_q != 16'hFFFF) mh[widx_q] <= rh_q + 16'd1;
			if (iconf_q > rc_q) begin
				mx[widx_q] <= ix_q;
				my[widx_q] <= iy_q;
				mz[widx_q] <= iz_q;
				mc[widx_q] <= iconf_q;
				mt[widx_q] <= itag_q;
			end
		end
	end

	// result register
	always_comb begin
		res_d = '0;
		if (act_q == dcd_pkg::ACT_DETECT) begin
			if (disp_q && !cmd.dispatch) res_d.kind = dcd_pkg::KIND_IGNORED;
			else begin
				res_d.kind = kind_q;
				if (kind_q != dcd_pkg::KIND_DROPPED) begin
					res_d.cluster_index = widx_q;
					res_d.hits = (kind_q == dcd_pkg::KIND_NEW) ? 16'd1 :
						(rh_q == 16'hFFFF ? rh_q : rh_q + 16'd1);
				end
			end
		end else if (act_q == dcd_pkg::ACT_TICK && cmd.dispatch && merge_upd_q == 1'b0
			&& disp_q && !stat.table_empty && kind_q == dcd_pkg::KIND_DISPATCH) begin
			res_d.kind = dcd_pkg::KIND_DISPATCH;
			res_d.cluster_index = widx_q;
			res_d.hits = rh_q;
			res_d.best_x = rx_q;
			res_d.best_y = ry_q;
			res_d.best_z = rz_q;
			res_d.best_confidence = rc_q;
			res_d.best_tag = rt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res_q <= res_d;
	end
	assign res = res_q;
endmodule

// ===== bench/tb_detection_cluster_dispatcher.sv =====
// Testbench for the detection cluster dispatcher: directed and random requests, scoreboard.
`timescale 1ns / 1ps
module tb_detection_cluster_dispatcher;
	localparam int CycleLimit = 3000000;

	typedef struct {
		logic [1:0] action;
		logic signed [23:0] x, y, z;
		logic [15:0] conf;
		logic [31:0] tag;
		logic [3:0] drone;
		logic [1:0] mode;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = dcd_pkg::REG_ACTIVE;
	logic [15:0] cfg_data = '0;

	detection_cluster_dispatcher DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model of the block
	logic [4:0] active_cnt;
	logic [15:0] radius, timeout_s;
	logic signed [23:0] cl_x[dcd_pkg::MaxClusters], cl_y[dcd_pkg::MaxClusters];
	logic signed [23:0] cl_z[dcd_pkg::MaxClusters];
	logic [15:0] cl_conf[dcd_pkg::MaxClusters], cl_hits[dcd_pkg::MaxClusters];
	logic [31:0] cl_tag[dcd_pkg::MaxClusters];
	int cl_total;
	logic [1:0] drone_st[dcd_pkg::MaxDrones];
	bit begun, dispatched;
	int ticks;

	dcd_pkg::result_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	int stall_left = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	function automatic longint sq(input logic signed [23:0] a, input logic signed [23:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	function automatic bit drones_reported();
		if (active_cnt > dcd_pkg::MaxDrones) return 1'b0;
		for (int i = 0; i < dcd_pkg::MaxDrones; i++) begin
			if (drone_st[i] == dcd_pkg::MODE_UNKNOWN) return 1'b0;
			if (i < active_cnt && drone_st[i] == dcd_pkg::MODE_ABSENT) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit drones_idle();
		for (int i = 0; i < dcd_pkg::MaxDrones; i++)
			if (drone_st[i] != dcd_pkg::MODE_ABSENT && drone_st[i] != dcd_pkg::MODE_IDLE)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_detect(input request_t r, inout dcd_pkg::result_t res);
		longint best, d;
		int idx;
		bit found;
		best = longint'(radius) * longint'(radius);
		idx = 0;
		found = 1'b0;
		if (dispatched) begin
			res.kind = dcd_pkg::KIND_IGNORED;
			return;
		end
		begun = 1'b1;
		for (int i = 0; i < cl_total; i++) begin
			d = sq(cl_x[i], r.x) + sq(cl_y[i], r.y) + sq(cl_z[i], r.z);
			if (d < best) begin
				best = d;
				idx = i;
				found = 1'b1;
			end
		end
		if (found) begin
			if (cl_hits[idx] != 16'hFFFF) cl_hits[idx]++;
			if (r.conf > cl_conf[idx]) begin
				cl_x[idx] = r.x; cl_y[idx] = r.y; cl_z[idx] = r.z;
				cl_conf[idx] = r.conf; cl_tag[idx] = r.tag;
			end
			res.kind = dcd_pkg::KIND_MERGED;
		end else if (cl_total < dcd_pkg::MaxClusters) begin
			idx = cl_total++;
			cl_x[idx] = r.x; cl_y[idx] = r.y; cl_z[idx] = r.z;
			cl_conf[idx] = r.conf; cl_tag[idx] = r.tag; cl_hits[idx] = 16'd1;
			res.kind = dcd_pkg::KIND_NEW;
		end else begin
			res.kind = dcd_pkg::KIND_DROPPED;
			return;
		end
		res.cluster_index = 6'(idx);
		res.hits = cl_hits[idx];
	endtask

	task automatic predict_tick(inout dcd_pkg::result_t res);
		longint best, score;
		int idx;
		if (dispatched) return;
		if (begun && ticks < dcd_pkg::TickMax) ticks++;
		if (!drones_reported() || !begun) return;
		if (!(drones_idle() || ticks > timeout_s) || cl_total == 0) return;
		best = 0;
		idx = 0;
		for (int i = 0; i < cl_total; i++) begin
			score = longint'(cl_conf[i]) * (10 + longint'(cl_hits[i]));
			if (i == 0 || score > best) begin
				best = score;
				idx = i;
			end
		end
		dispatched = 1'b1;
		res.kind = dcd_pkg::KIND_DISPATCH;
		res.cluster_index = 6'(idx);
		res.hits = cl_hits[idx];
		res.best_x = cl_x[idx];
		res.best_y = cl_y[idx];
		res.best_z = cl_z[idx];
		res.best_confidence = cl_conf[idx];
		res.best_tag = cl_tag[idx];
	endtask

	task automatic predict_request(input request_t r);
		dcd_pkg::result_t res;
		res = '0;
		case (r.action)
			dcd_pkg::ACT_DETECT: predict_detect(r, res);
			dcd_pkg::ACT_STATUS: drone_st[r.drone] =
				(r.mode == dcd_pkg::MODE_ABSENT) ? dcd_pkg::MODE_BUSY : r.mode;
			dcd_pkg::ACT_TICK: predict_tick(res);
			default: ;
		endcase
		pending_results = {pending_results, res};
	endtask

	function automatic int pick_gap();
		if (!gaps_on) return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
	endfunction

	task automatic send_request(input request_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {2'b0, r.mode, r.drone, r.tag, r.conf, r.z, r.y, r.x};
		s_axis_tuser = r.action;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_request(r);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		drain();
		cfg_index = idx;
		cfg_data = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			dcd_pkg::REG_ACTIVE: active_cnt = value[4:0];
			dcd_pkg::REG_RADIUS: radius = value;
			dcd_pkg::REG_TIMEOUT: timeout_s = value;
			default: ;
		endcase
	endtask

	function automatic request_t random_fields(input logic [1:0] action);
		request_t r;
		r.action = action;
		r.x = 24'($urandom); r.y = 24'($urandom); r.z = 24'($urandom);
		r.conf = 16'($urandom); r.tag = $urandom;
		r.drone = 4'($urandom); r.mode = 2'($urandom);
		return r;
	endfunction

	function automatic request_t detection(input int x, input int y, input int z,
			input logic [15:0] conf, input logic [31:0] tag);
		request_t r;
		r = random_fields(dcd_pkg::ACT_DETECT);
		r.x = 24'(x); r.y = 24'(y); r.z = 24'(z); r.conf = conf; r.tag = tag;
		return r;
	endfunction

	function automatic request_t status(input logic [3:0] drone, input logic [1:0] mode);
		request_t r;
		r = random_fields(dcd_pkg::ACT_STATUS);
		r.drone = drone; r.mode = mode;
		return r;
	endfunction

	task automatic test_directed();
		send_request(random_fields(dcd_pkg::ACT_TICK));   // tick before the mission starts
		send_request(status(4'd3, dcd_pkg::MODE_ABSENT)); // mode three counts as busy
		send_request(random_fields(2'd3));                 // undefined action
		send_request(detection(8388607, 8388607, 8388607, 16'd0, 32'd0));
		send_request(detection(-8388608, -8388608, -8388608, 16'hFFFF, 32'hFFFFFFFF));
		send_request(detection(8388600, 8388607, 8388607, 16'd5, 32'h1234));  // merge, replace
		send_request(detection(8388607, 8388600, 8388607, 16'd5, 32'h5678));  // equal conf
		send_request(detection(8388607, 8388607, 8388607, 16'd1, 32'h9abc));  // lower conf
		send_request(detection(0, 0, 0, 16'd100, 32'd1));
		send_request(detection(256, 0, 0, 16'd100, 32'd2));     // exactly on the radius
		send_request(detection(0, 0, 600, 16'd100, 32'd3));
		send_request(detection(128, 0, 0, 16'd50, 32'd4));      // equidistant, lower index wins
		send_request(random_fields(dcd_pkg::ACT_TICK));
		send_request(status(4'd9, dcd_pkg::MODE_UNKNOWN));
		send_request(status(4'd15, dcd_pkg::MODE_IDLE));
		write_reg(dcd_pkg::REG_RADIUS, 16'd0);
		send_request(detection(0, 0, 0, 16'd7, 32'd5));          // nothing can merge
		write_reg(dcd_pkg::REG_RADIUS, 16'hFFFF);
		send_request(detection(1000, -1000, 20000, 16'd300, 32'd6));
		send_request(detection(-65535, 0, 0, 16'd1, 32'd7));
		send_request(random_fields(dcd_pkg::ACT_TICK));
	endtask

	task automatic test_random_clusters();
		logic [15:0] radii[4] = '{16'd16, 16'd256, 16'd4000, 16'hFFFF};
		int cx[8], cy[8], cz[8];
		int span, c, sel;
		write_reg(dcd_pkg::REG_ACTIVE, 16'd17);         // keeps dispatch off
		write_reg(dcd_pkg::REG_TIMEOUT, 16'd0);
		for (int round = 0; round < 4; round++) begin
			write_reg(dcd_pkg::REG_RADIUS, radii[round]);
			gaps_on = (round != 1);
			stalls_on = (round != 2);
			span = int'(radii[round]);
			for (int k = 0; k < 8; k++) begin
				cx[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
				cy[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
				cz[k] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
			end
			for (int n = 0; n < 370; n++) begin
				sel = $urandom_range(0, 99);
				c = $urandom_range(0, 7);
				if (sel < 60)
					send_request(detection(cx[c] + $urandom_range(0, span) - span / 2,
						cy[c] + $urandom_range(0, span) - span / 2,
						cz[c] + $urandom_range(0, span / 4), 16'($urandom), $urandom));
				else if (sel < 72)
					send_request(random_fields(dcd_pkg::ACT_DETECT));
				else if (sel < 85)
					send_request(random_fields(dcd_pkg::ACT_STATUS));
				else if (sel < 97)
					send_request(random_fields(dcd_pkg::ACT_TICK));
				else
					send_request(random_fields(2'd3));
			end
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_dispatch();
		bit by_idle;
		by_idle = 1'($urandom_range(0, 1));
		write_reg(dcd_pkg::REG_ACTIVE, 16'd1);
		write_reg(dcd_pkg::REG_ACTIVE, 16'd0);
		write_reg(dcd_pkg::REG_TIMEOUT, 16'hFFFF);
		write_reg(dcd_pkg::REG_ACTIVE, 16'd16);
		for (int d = 0; d < dcd_pkg::MaxDrones; d++)
			send_request(status(4'(d), (d == 5) ? dcd_pkg::MODE_ABSENT : dcd_pkg::MODE_IDLE));
		send_request(random_fields(dcd_pkg::ACT_TICK));   // drone five busy, far from timeout
		if (by_idle) begin
			send_request(status(4'd5, dcd_pkg::MODE_IDLE));
		end else begin
			send_request(status(4'd5, dcd_pkg::MODE_BUSY));
			write_reg(dcd_pkg::REG_TIMEOUT, 16'd0);
		end
		send_request(random_fields(dcd_pkg::ACT_TICK));
		send_request(random_fields(dcd_pkg::ACT_TICK));
	endtask

	task automatic test_after_dispatch();
		for (int n = 0; n < 200; n++)
			send_request(random_fields(2'($urandom_range(0, 3))));
	endtask

	// output stalls: mostly short, now and then long
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready = 1'b0;
		end else if (stalls_on && $urandom_range(0, 99) < 25) begin
			stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) :
				$urandom_range(5, 40);
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		dcd_pkg::result_t want, got;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.cluster_index = m_axis_tdata[5:0];
			got.hits = m_axis_tdata[21:6];
			got.best_x = m_axis_tdata[45:22];
			got.best_y = m_axis_tdata[69:46];
			got.best_z = m_axis_tdata[93:70];
			got.best_confidence = m_axis_tdata[109:94];
			got.best_tag = m_axis_tdata[141:110];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kind %0d", got.kind);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.cluster_index !== want.cluster_index ||
						got.hits !== want.hits || got.best_x !== want.best_x ||
						got.best_y !== want.best_y || got.best_z !== want.best_z ||
						got.best_confidence !== want.best_confidence ||
						got.best_tag !== want.best_tag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	initial begin
		active_cnt = 5'd4;
		radius = 16'd256;
		timeout_s = 16'd60;
		cl_total = 0;
		foreach (drone_st[i]) drone_st[i] = dcd_pkg::MODE_ABSENT;
		begun = 1'b0;
		dispatched = 1'b0;
		ticks = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_clusters();
		test_dispatch();
		test_after_dispatch();
		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
